>>> rtl/ftsc_pkg.sv
package ftsc_pkg;

  localparam logic [31:0] CrcPoly        = 32'hEDB8_8320;
  localparam logic [31:0] MaxBytesReset  = 32'h0400_0000;
  localparam logic [7:0]  VersionWanted  = 8'd1;

  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoPtrW  = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  localparam int unsigned InDataW  = 88;
  localparam int unsigned InUserW  = 3;
  localparam int unsigned OutDataW = 72;

  typedef enum logic [2:0] {
    OP_START      = 3'd0,
    OP_DATA       = 3'd1,
    OP_FINISH     = 3'd2,
    OP_ABORT      = 3'd3,
    OP_DISCONNECT = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    CMD_START,
    CMD_DATA,
    CMD_FINISH,
    CMD_ABORT,
    CMD_DISCONNECT,
    CMD_UNKNOWN
  } cmd_kind_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_RECV = 2'd1,
    PH_DONE = 2'd2,
    PH_FAIL = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    NT_NONE  = 2'd0,
    NT_START = 2'd1,
    NT_DONE  = 2'd2,
    NT_ERR   = 2'd3
  } notice_e;

  typedef enum logic [3:0] {
    EC_NONE      = 4'd0,
    EC_BUSY      = 4'd1,
    EC_PROTO     = 4'd2,
    EC_NAME      = 4'd3,
    EC_EXTENSION = 4'd4,
    EC_SIZE      = 4'd5,
    EC_STATE     = 4'd6,
    EC_OVERFLOW  = 4'd7,
    EC_TRUNCATED = 4'd8,
    EC_CRC       = 4'd9,
    EC_ABORTED   = 4'd10
  } err_e;

  typedef enum logic [1:0] {
    NV_FINE      = 2'd0,
    NV_UNSAFE    = 2'd1,
    NV_EXTENSION = 2'd2
  } verdict_e;

  typedef struct packed {
    cmd_kind_e   kind;
    err_e        start_err;
    logic [31:0] size;
    logic [31:0] crc;
    logic [7:0]  data_byte;
  } cmd_t;

  function automatic logic [31:0] crc32_byte(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] c;
    c = ~acc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return ~c;
  endfunction

endpackage

>>> rtl/ftsc_front.sv
module ftsc_front
  import ftsc_pkg::*;
(
  input  logic [31:0]        max_bytes_i,
  input  logic [InUserW-1:0] op_i,
  input  logic [InDataW-1:0] data_i,
  output cmd_t               cmd_o
);

  logic [7:0]  version;
  logic [1:0]  verdict;
  logic [31:0] size;

  assign version = data_i[7:0];
  assign verdict = data_i[9:8];
  assign size    = data_i[41:10];

  always_comb begin
    cmd_o.size      = size;
    cmd_o.crc       = data_i[73:42];
    cmd_o.data_byte = data_i[81:74];

    unique case (op_i)
      OP_START:      cmd_o.kind = CMD_START;
      OP_DATA:       cmd_o.kind = CMD_DATA;
      OP_FINISH:     cmd_o.kind = CMD_FINISH;
      OP_ABORT:      cmd_o.kind = CMD_ABORT;
      OP_DISCONNECT: cmd_o.kind = CMD_DISCONNECT;
      default:       cmd_o.kind = CMD_UNKNOWN;
    endcase

    if (version != VersionWanted) begin
      cmd_o.start_err = EC_PROTO;
    end else if (verdict == NV_EXTENSION) begin
      cmd_o.start_err = EC_EXTENSION;
    end else if (verdict != NV_FINE) begin
      cmd_o.start_err = EC_NAME;
    end else if (size == 32'd0 || size > max_bytes_i) begin
      cmd_o.start_err = EC_SIZE;
    end else begin
      cmd_o.start_err = EC_NONE;
    end
  end

endmodule

>>> rtl/ftsc_fifo.sv
module ftsc_fifo
  import ftsc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t pop_data_o,
  output logic empty_o
);

  cmd_t                mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FifoCntW-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == FifoCntW'(FifoDepth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> rtl/ftsc_back.sv
module ftsc_back
  import ftsc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  cmd_t                cmd_i,
  output logic                cmd_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [OutDataW-1:0] out_data_o
);

  phase_e      phase_q, phase_d;
  logic [31:0] total_q, total_d;
  logic [31:0] count_q, count_d;
  logic [31:0] exp_crc_q, exp_crc_d;
  logic [31:0] crc_q, crc_d;
  logic                out_valid_q, out_valid_d;
  logic [OutDataW-1:0] out_data_q, out_data_d;
  notice_e     notice;
  err_e        err;
  logic        recv;
  logic        do_fail;

  assign recv      = (phase_q == PH_RECV);
  assign cmd_pop_o = cmd_valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    phase_d   = phase_q;
    total_d   = total_q;
    count_d   = count_q;
    exp_crc_d = exp_crc_q;
    crc_d     = crc_q;
    notice    = NT_NONE;
    err       = EC_NONE;
    do_fail   = 1'b0;

    case (cmd_i.kind)
      CMD_START: begin
        if (recv) begin
          err = EC_BUSY;
        end else begin
          err = cmd_i.start_err;
        end
        if (err != EC_NONE) begin
          notice = NT_ERR;
        end else begin
          phase_d   = PH_RECV;
          total_d   = cmd_i.size;
          count_d   = '0;
          exp_crc_d = cmd_i.crc;
          crc_d     = '0;
          notice    = NT_START;
        end
      end
      CMD_DATA: begin
        if (recv) begin
          if (count_q >= total_q) begin
            do_fail = 1'b1;
            err     = EC_OVERFLOW;
          end else begin
            count_d = count_q + 32'd1;
            crc_d   = crc32_byte(crc_q, cmd_i.data_byte);
          end
        end
      end
      CMD_FINISH: begin
        if (!recv) begin
          err = EC_STATE;
        end else if (count_q != total_q) begin
          do_fail = 1'b1;
          err     = EC_TRUNCATED;
        end else if (crc_q != exp_crc_q) begin
          do_fail = 1'b1;
          err     = EC_CRC;
        end else begin
          phase_d = PH_DONE;
          total_d = '0;
          count_d = '0;
          crc_d   = '0;
          notice  = NT_DONE;
        end
      end
      CMD_ABORT: begin
        do_fail = 1'b1;
        err     = EC_ABORTED;
      end
      CMD_DISCONNECT: begin
        if (recv) begin
          do_fail = 1'b1;
          err     = EC_ABORTED;
        end
      end
      default: begin
        err = EC_PROTO;
      end
    endcase

    if (do_fail) begin
      phase_d = PH_FAIL;
      total_d = '0;
      count_d = '0;
      crc_d   = '0;
    end
    if (err != EC_NONE) begin
      notice = NT_ERR;
    end

    if (!cmd_pop_o) begin
      phase_d   = phase_q;
      total_d   = total_q;
      count_d   = count_q;
      exp_crc_d = exp_crc_q;
      crc_d     = crc_q;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (cmd_pop_o) begin
      out_valid_d = 1'b1;
      out_data_d  = {crc_d, count_d, err, notice, phase_d};
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      total_q     <= '0;
      count_q     <= '0;
      exp_crc_q   <= '0;
      crc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      total_q     <= total_d;
      count_q     <= count_d;
      exp_crc_q   <= exp_crc_d;
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> rtl/file_transfer_session_checker_top.sv
// Receiver-side checker for a file-transfer session, one event per beat.
// The slave channel takes an event: tuser carries the operation (start, data
// byte, finish, abort, disconnect) and tdata the version, name verdict,
// promised size, promised CRC and data byte. The master channel returns one
// result beat per event with the phase, notice, error code, byte count and
// running CRC32 after that event.
// The configuration port writes the largest promised size a start may carry;
// write it only while no event is in flight.
// Throughput is one event per cycle while the receiver takes every result beat.
// Each event is decoded and registered in the command queue, then the back end,
// whose session state, byte counter and one-byte CRC32 update are combinational,
// registers the result.
// Reset returns the session to idle with all counters and CRCs at zero and
// the size limit at 64 MiB. When the receiver stalls, the result holds in
// the output register, the two-entry command queue fills, and tready drops
// once the queue is full.
module file_transfer_session_checker_top
  import ftsc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [31:0]         cfg_wdata_i,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // sender version, name verdict, promised size, promised CRC, data byte, zero pad
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // operation
  input  logic [InUserW-1:0]  s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // phase, notice, error_code, received_count, running_crc_out
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  logic [31:0] max_bytes_q;
  cmd_t        front_cmd;
  cmd_t        queue_cmd;
  logic        queue_full;
  logic        queue_empty;
  logic        queue_pop;
  logic        push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bytes_q <= MaxBytesReset;
    end else if (cfg_we_i) begin
      max_bytes_q <= cfg_wdata_i;
    end
  end

  assign s_axis_tready_o = !queue_full;
  assign push            = s_axis_tvalid_i && !queue_full;

  ftsc_front u_front (
    .max_bytes_i (max_bytes_q),
    .op_i        (s_axis_tuser_i),
    .data_i      (s_axis_tdata_i),
    .cmd_o       (front_cmd)
  );

  ftsc_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (front_cmd),
    .full_o      (queue_full),
    .pop_i       (queue_pop),
    .pop_data_o  (queue_cmd),
    .empty_o     (queue_empty)
  );

  ftsc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!queue_empty),
    .cmd_i       (queue_cmd),
    .cmd_pop_o   (queue_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule

>>> rtl/ftsc_checker.sv
module ftsc_checker
  import ftsc_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid_o,
  input logic                m_axis_tready_i,
  input logic [OutDataW-1:0] m_axis_tdata_o
);

  logic [1:0]  phase;
  logic [1:0]  notice;
  logic [3:0]  err;
  logic [31:0] count;
  logic [31:0] crc;

  assign phase  = m_axis_tdata_o[1:0];
  assign notice = m_axis_tdata_o[3:2];
  assign err    = m_axis_tdata_o[7:4];
  assign count  = m_axis_tdata_o[39:8];
  assign crc    = m_axis_tdata_o[71:40];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("Result beat changed while stalled.");

  a_err_iff_notice: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ((notice == NT_ERR) == (err != EC_NONE)))
    else $error("Error code and error notice disagree.");

  a_start_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && notice == NT_START |->
      phase == PH_RECV && count == 32'd0 && crc == 32'd0)
    else $error("Started session is not clean.");

  a_done_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && notice == NT_DONE |->
      phase == PH_DONE && count == 32'd0 && crc == 32'd0)
    else $error("Completed session is not cleared.");

  a_fail_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (err == EC_OVERFLOW || err == EC_TRUNCATED || err == EC_CRC ||
      err == EC_ABORTED) |-> phase == PH_FAIL && count == 32'd0)
    else $error("Session failure did not reach the failed phase.");

endmodule

bind file_transfer_session_checker_top ftsc_checker u_ftsc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

>>> dv/ftsc_session_checker.sv
`timescale 1ns / 1ps

package ftsc_tb_pkg;

  function automatic logic [31:0] crc_update(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] r;
    r = ~crc;
    for (int i = 0; i < 8; i++) begin
      r = (r[0] ^ b[i]) ? ({1'b0, r[31:1]} ^ ftsc_pkg::CrcPoly) : {1'b0, r[31:1]};
    end
    return ~r;
  endfunction

endpackage

module ftsc_session_checker
  import ftsc_pkg::*;
  import ftsc_tb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [31:0]         cfg_wdata_i,
  input  logic                s_valid_i,
  input  logic                s_ready_i,
  input  logic [InDataW-1:0]  s_data_i,
  input  logic [InUserW-1:0]  s_user_i,
  input  logic                m_valid_i,
  input  logic                m_ready_i,
  input  logic [OutDataW-1:0] m_data_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o
);

  typedef struct packed {
    phase_e      phase;
    notice_e     notice;
    err_e        err;
    logic [31:0] count;
    logic [31:0] crc;
  } outcome_t;

  outcome_t    outcome_q[$];
  int unsigned fails;

  phase_e      sess_phase;
  logic [31:0] size_promised;
  logic [31:0] bytes_seen;
  logic [31:0] crc_promised;
  logic [31:0] crc_running;
  logic [31:0] size_limit;

  function automatic int field_bad(string label, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    logic [2:0]  op;
    logic [7:0]  ver;
    logic [1:0]  verdict;
    logic [31:0] size;
    logic [31:0] pcrc;
    logic [7:0]  db;
    logic        recv;
    err_e        err;
    notice_e     note;
    outcome_t    want;
    if (!rst_ni) begin
      sess_phase    = PH_IDLE;
      size_promised = '0;
      bytes_seen    = '0;
      crc_promised  = '0;
      crc_running   = '0;
      size_limit    = MaxBytesReset;
      outcome_q.delete();
      pending_o    <= 0;
      fail_count_o <= fails;
    end else begin
      if (m_valid_i && m_ready_i) begin
        if (outcome_q.size() == 0) begin
          $display("%0t: result beat with nothing expected, actual %0h", $time, m_data_i);
          fails++;
        end else begin
          want = outcome_q.pop_front();
          fails += field_bad("phase", 32'(want.phase), 32'(m_data_i[1:0]));
          fails += field_bad("notice", 32'(want.notice), 32'(m_data_i[3:2]));
          fails += field_bad("error_code", 32'(want.err), 32'(m_data_i[7:4]));
          fails += field_bad("received_count", want.count, m_data_i[39:8]);
          fails += field_bad("running_crc", want.crc, m_data_i[71:40]);
        end
      end

      if (s_valid_i && s_ready_i) begin
        op      = s_user_i;
        ver     = s_data_i[7:0];
        verdict = s_data_i[9:8];
        size    = s_data_i[41:10];
        pcrc    = s_data_i[73:42];
        db      = s_data_i[81:74];
        recv    = (sess_phase == PH_RECV);
        err     = EC_NONE;
        note    = NT_NONE;
        case (op)
          OP_START: begin
            if (recv) err = EC_BUSY;
            else if (ver != VersionWanted) err = EC_PROTO;
            else if (verdict == NV_EXTENSION) err = EC_EXTENSION;
            else if (verdict != NV_FINE) err = EC_NAME;
            else if (size == 0 || size > size_limit) err = EC_SIZE;
            if (err == EC_NONE) begin
              sess_phase    = PH_RECV;
              size_promised = size;
              bytes_seen    = '0;
              crc_promised  = pcrc;
              crc_running   = '0;
              note          = NT_START;
            end
          end
          OP_DATA: begin
            if (recv) begin
              if (bytes_seen >= size_promised) begin
                err = EC_OVERFLOW;
              end else begin
                bytes_seen  = bytes_seen + 1;
                crc_running = crc_update(crc_running, db);
              end
            end
          end
          OP_FINISH: begin
            if (!recv) err = EC_STATE;
            else if (bytes_seen != size_promised) err = EC_TRUNCATED;
            else if (crc_running != crc_promised) err = EC_CRC;
            else begin
              sess_phase    = PH_DONE;
              size_promised = '0;
              bytes_seen    = '0;
              crc_running   = '0;
              note          = NT_DONE;
            end
          end
          OP_ABORT: err = EC_ABORTED;
          OP_DISCONNECT: begin
            if (recv) err = EC_ABORTED;
          end
          default: err = EC_PROTO;
        endcase
        if (err != EC_NONE) begin
          note = NT_ERR;
          if (err == EC_OVERFLOW || err == EC_TRUNCATED || err == EC_CRC ||
              err == EC_ABORTED) begin
            sess_phase    = PH_FAIL;
            size_promised = '0;
            bytes_seen    = '0;
            crc_running   = '0;
          end
        end
        want = '{phase: sess_phase, notice: note, err: err, count: bytes_seen,
                 crc: crc_running};
        outcome_q.push_back(want);
      end

      if (cfg_we_i) begin
        size_limit = cfg_wdata_i;
      end

      pending_o    <= outcome_q.size();
      fail_count_o <= fails;
    end
  end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import ftsc_pkg::*;
  import ftsc_tb_pkg::*;

  localparam logic [2:0] OpUnknownLo = 3'd5;
  localparam logic [2:0] OpUnknownHi = 3'd7;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [31:0]         cfg_wdata;
  logic                s_tvalid;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata;
  logic [InUserW-1:0]  s_tuser;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  int unsigned         fail_count;
  int unsigned         pending;

  int unsigned burst_left = 0;
  int unsigned beats_sent = 0;
  int unsigned stall_left = 0;
  int unsigned stall_mode = 0;

  file_transfer_session_checker_top dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  ftsc_session_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .s_valid_i    (s_tvalid),
    .s_ready_i    (s_tready),
    .s_data_i     (s_tdata),
    .s_user_i     (s_tuser),
    .m_valid_i    (m_tvalid),
    .m_ready_i    (m_tready),
    .m_data_i     (m_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // The receiver switches between stretches of full speed, light and heavy
  // random stalls, and a fixed on/off rhythm.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 120);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      2: m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= ((stall_left % 7) < 4);
    endcase
  end

  task automatic send_beat(input logic [2:0] op, input logic [7:0] ver,
                           input logic [1:0] verdict, input logic [31:0] size,
                           input logic [31:0] crc, input logic [7:0] db);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, db, crc, size, verdict, ver};
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    burst_left--;
    beats_sent++;
  endtask

  task automatic open_session(input logic [31:0] size, input logic [31:0] crc);
    send_beat(OP_START, VersionWanted, NV_FINE, size, crc, 8'($urandom));
  endtask

  task automatic send_byte(input logic [7:0] db);
    send_beat(OP_DATA, 8'($urandom), 2'($urandom), $urandom, $urandom, db);
  endtask

  task automatic send_plain(input logic [2:0] op);
    send_beat(op, 8'($urandom), 2'($urandom), $urandom, $urandom, 8'($urandom));
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [31:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // A mostly well-formed session; some are corrupted by a bad CRC, a short or
  // long payload, a disconnect, an abort, a second start or a missing finish.
  task automatic send_session(input int unsigned limit);
    logic [7:0]  payload [48];
    logic [31:0] crc;
    int unsigned n;
    int unsigned sent;
    int unsigned kind;
    int unsigned cut;
    if ($urandom_range(0, 15) == 0) n = $urandom_range(1, (limit < 48) ? limit : 48);
    else n = $urandom_range(1, (limit < 12) ? limit : 12);
    crc = '0;
    for (int i = 0; i < n; i++) begin
      payload[i] = 8'($urandom);
      crc = crc_update(crc, payload[i]);
    end
    kind = $urandom_range(0, 19);
    sent = n;
    if (kind == 0) crc ^= 32'h1 << $urandom_range(0, 31);
    if (kind == 1) sent = n - 1;
    if (kind == 2) sent = n + $urandom_range(1, 3);
    cut = $urandom_range(0, n - 1);
    open_session(n, crc);
    for (int i = 0; i < sent; i++) begin
      if (i == cut) begin
        case (kind)
          3: send_plain(OP_DISCONNECT);
          4: send_plain(OP_ABORT);
          5: open_session($urandom_range(1, 8), $urandom);
          default: ;
        endcase
      end
      send_byte((i < n) ? payload[i] : 8'($urandom));
    end
    if (kind != 6) send_plain(OP_FINISH);
  endtask

  task automatic run_phase(input int unsigned limit, input int unsigned count);
    int unsigned target;
    int unsigned r;
    target = beats_sent + count;
    while (beats_sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        send_session(limit);
      end else if (r < 97) begin
        repeat ($urandom_range(1, 3)) begin
          send_beat(3'($urandom_range(0, 7)),
                    ($urandom_range(0, 2) == 0) ? 8'($urandom) : VersionWanted,
                    ($urandom_range(0, 3) == 0) ? 2'($urandom) : 2'(NV_FINE),
                    ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 16),
                    $urandom, 8'($urandom));
        end
      end else begin
        wait_idle();
      end
    end
  endtask

  initial begin
    logic [31:0] crc_acc;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_plain(OP_ABORT);
    send_plain(OP_FINISH);
    send_byte(8'hFF);
    send_plain(OP_DISCONNECT);
    send_beat(OP_START, 8'h00, NV_FINE, 32'd4, 32'd0, 8'h00);
    send_beat(OP_START, 8'hFF, NV_FINE, 32'd4, 32'd0, 8'h00);
    send_beat(OP_START, VersionWanted, NV_UNSAFE, 32'd4, 32'd0, 8'h00);
    send_beat(OP_START, VersionWanted, NV_EXTENSION, 32'd4, 32'd0, 8'h00);
    send_beat(OP_START, VersionWanted, 2'b11, 32'd4, 32'd0, 8'h00);
    send_beat(OP_START, VersionWanted, NV_FINE, 32'd0, 32'd0, 8'h00);
    send_beat(OP_START, VersionWanted, NV_FINE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
    send_beat(OP_START, VersionWanted, NV_FINE, MaxBytesReset + 32'd1, 32'd0, 8'h00);
    send_plain(OpUnknownLo);
    send_plain(OpUnknownHi);
    open_session(MaxBytesReset, 32'hFFFF_FFFF);
    open_session(32'd3, 32'd0);
    send_plain(OP_DISCONNECT);
    crc_acc = crc_update(crc_update(crc_update(32'd0, 8'h00), 8'hFF), 8'hA5);
    open_session(32'd3, crc_acc);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hA5);
    send_plain(OP_FINISH);
    send_byte(8'h5A);
    open_session(32'd1, 32'd0);
    send_byte(8'h01);
    send_byte(8'h02);
    send_plain(OP_FINISH);

    write_limit(32'd1);
    run_phase(1, 260);
    write_limit(32'hFFFF_FFFF);
    run_phase(32'hFFFF_FFFF, 280);
    write_limit(32'd5);
    run_phase(5, 270);
    write_limit(MaxBytesReset);
    run_phase(MaxBytesReset, 280);

    wait_idle();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
